// ===== hw/rtl/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// Timer expiry queue package
// Shared command codes, transfer types and controller/datapath interface types.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int ID_W        = 4;
    localparam int IN_DELAY_W  = 24;
    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    typedef struct packed {
        logic [1:0]            command;
        logic [ID_W-1:0]       timer_id;
        logic [IN_DELAY_W-1:0] start_delay;
        logic                  start_restart;
    } in_item_t;

    typedef struct packed {
        logic            expired_valid;
        logic [ID_W-1:0] expired_id;
        logic            queue_was_busy;
        logic            last_result;
    } out_item_t;

    typedef enum logic [2:0] {
        DP_HOLD,
        DP_LOAD,
        DP_DEC,
        DP_POP,
        DP_REMOVE,
        DP_INSERT
    } dp_op_t;

    typedef struct packed {
        logic            head_zero;
        logic            next_zero;
        logic            head_restart;
        logic [ID_W-1:0] head_id;
        logic            queue_busy;
    } dp_status_t;

    typedef struct packed {
        logic emit;
        logic hit;
        logic last;
    } res_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEC,
        ST_POP,
        ST_REINS,
        ST_REMOVE,
        ST_INSERT
    } ctrl_state_t;

endpackage

// ===== hw/rtl/software_timer_expiry_queue_unit.sv =====
// ----------------------------------------------------------------------------
// Software timer expiry queue
// Bank of one-shot and auto-restart timers kept in a row sorted by expiry.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; a start or stop
// whose timer_id is not below NUM_TIMERS is ignored. A stop removes any earlier
// arming; a start removes it, then does a sorted insert into the cell row. A
// tick first counts every cell down, then the expiry loop pops one expired head
// per cycle, save that after each pop of a restart timer it first re-inserts
// that timer. Each result appears on result for one cycle with result_valid
// high, in the cycle after it is formed; the consumer must take it then, as
// there is no back-pressure.
module software_timer_expiry_queue_unit #(
    parameter int NUM_TIMERS = 16,
    parameter int DELAY_BITS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  stq_pkg::in_item_t  item,
    output logic               busy,
    output logic               result_valid,
    output stq_pkg::out_item_t result
);

    stq_pkg::dp_op_t     op;
    stq_pkg::dp_status_t status;
    stq_pkg::res_ctl_t   res_ctl;
    logic                result_valid_reg;
    stq_pkg::out_item_t  result_reg;

    stq_controller #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .item    (item),
        .status  (status),
        .busy    (busy),
        .op      (op),
        .res_ctl (res_ctl)
    );

    stq_datapath #(
        .NUM_TIMERS (NUM_TIMERS),
        .DELAY_BITS (DELAY_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (op),
        .item   (item),
        .status (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= res_ctl.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ctl.emit)
        begin
            result_reg.expired_valid  <= res_ctl.hit;
            result_reg.expired_id     <= res_ctl.hit ? status.head_id : '0;
            result_reg.queue_was_busy <= status.queue_busy;
            result_reg.last_result    <= res_ctl.last;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef ASSERT_OFF
    a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last_result) |-> busy)
        else $error("non-final result while block is idle");

    a_miss_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.expired_valid) |-> result.last_result)
        else $error("empty tick result not marked final");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.command == stq_pkg::CMD_TICK) |=> busy)
        else $error("tick accepted without entering busy");
`endif

endmodule

// ===== hw/rtl/stq_datapath.sv =====
// ----------------------------------------------------------------------------
// Timer expiry queue datapath
// Sorted row of timer cells with parallel decrement, pop, remove and insert.
// ----------------------------------------------------------------------------
module stq_datapath #(
    parameter int NUM_TIMERS = 16,
    parameter int DELAY_BITS = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  stq_pkg::dp_op_t     op,
    input  stq_pkg::in_item_t   item,
    output stq_pkg::dp_status_t status
);

    localparam int ID_W = stq_pkg::ID_W;
    localparam int WIDE_W = (DELAY_BITS > stq_pkg::IN_DELAY_W) ? DELAY_BITS
                                                              : stq_pkg::IN_DELAY_W;

    logic [NUM_TIMERS-1:0] vld_reg, vld_next;
    logic [ID_W-1:0]       id_reg  [NUM_TIMERS];
    logic [ID_W-1:0]       id_next [NUM_TIMERS];
    logic [DELAY_BITS-1:0] rem_reg  [NUM_TIMERS];
    logic [DELAY_BITS-1:0] rem_next [NUM_TIMERS];
    logic [DELAY_BITS-1:0] rel_reg  [NUM_TIMERS];
    logic [DELAY_BITS-1:0] rel_next [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] rst_reg, rst_next;

    logic [ID_W-1:0]       pend_id_reg, pend_id_next;
    logic [DELAY_BITS-1:0] pend_rel_reg, pend_rel_next;
    logic                  pend_rst_reg, pend_rst_next;
    logic                  busy_reg, busy_next;

    logic [NUM_TIMERS-1:0] up_vld, up_rst, dn_vld, dn_rst;
    logic [ID_W-1:0]       up_id  [NUM_TIMERS];
    logic [ID_W-1:0]       dn_id  [NUM_TIMERS];
    logic [DELAY_BITS-1:0] up_rem [NUM_TIMERS];
    logic [DELAY_BITS-1:0] dn_rem [NUM_TIMERS];
    logic [DELAY_BITS-1:0] up_rel [NUM_TIMERS];
    logic [DELAY_BITS-1:0] dn_rel [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] match, gone, lt, dn_lt, at_pos;
    logic [WIDE_W-1:0]     delay_wide;
    logic [DELAY_BITS-1:0] delay_trunc;

    // neighbor views and per-cell compares
    always_comb
    begin
        for (int k = 0; k < NUM_TIMERS - 1; k++)
        begin
            up_vld[k] = vld_reg[k+1];
            up_id[k]  = id_reg[k+1];
            up_rem[k] = rem_reg[k+1];
            up_rel[k] = rel_reg[k+1];
            up_rst[k] = rst_reg[k+1];
        end
        up_vld[NUM_TIMERS-1] = 1'b0;
        up_id[NUM_TIMERS-1]  = '0;
        up_rem[NUM_TIMERS-1] = '0;
        up_rel[NUM_TIMERS-1] = '0;
        up_rst[NUM_TIMERS-1] = 1'b0;

        for (int k = 1; k < NUM_TIMERS; k++)
        begin
            dn_vld[k] = vld_reg[k-1];
            dn_id[k]  = id_reg[k-1];
            dn_rem[k] = rem_reg[k-1];
            dn_rel[k] = rel_reg[k-1];
            dn_rst[k] = rst_reg[k-1];
        end
        dn_vld[0] = 1'b0;
        dn_id[0]  = '0;
        dn_rem[0] = '0;
        dn_rel[0] = '0;
        dn_rst[0] = 1'b0;

        for (int k = 0; k < NUM_TIMERS; k++)
        begin
            match[k] = vld_reg[k] && (id_reg[k] == pend_id_reg);
            lt[k]    = vld_reg[k] && (rem_reg[k] < pend_rel_reg);
        end

        // cell k shifts down on remove when the match sits at or below it
        for (int k = 0; k < NUM_TIMERS; k++)
        begin
            gone[k] = 1'b0;
            for (int j = 0; j < NUM_TIMERS; j++)
            begin
                if (j <= k)
                begin
                    gone[k] = gone[k] | match[j];
                end
            end
        end

        dn_lt[0] = 1'b1;
        for (int k = 1; k < NUM_TIMERS; k++)
        begin
            dn_lt[k] = lt[k-1];
        end
        at_pos = ~lt & dn_lt;
    end

    assign delay_wide  = WIDE_W'(item.start_delay);
    assign delay_trunc = delay_wide[DELAY_BITS-1:0];

    always_comb
    begin
        vld_next      = vld_reg;
        rst_next      = rst_reg;
        pend_id_next  = pend_id_reg;
        pend_rel_next = pend_rel_reg;
        pend_rst_next = pend_rst_reg;
        busy_next     = busy_reg;
        for (int k = 0; k < NUM_TIMERS; k++)
        begin
            id_next[k]  = id_reg[k];
            rem_next[k] = rem_reg[k];
            rel_next[k] = rel_reg[k];
        end

        unique case (op)
            stq_pkg::DP_HOLD:
            begin
            end
            stq_pkg::DP_LOAD:
            begin
                pend_id_next  = item.timer_id;
                pend_rst_next = item.start_restart;
                // a zero delay counts as one tick
                pend_rel_next = (delay_trunc == '0) ? DELAY_BITS'(1) : delay_trunc;
            end
            stq_pkg::DP_DEC:
            begin
                busy_next = |vld_reg;
                for (int k = 0; k < NUM_TIMERS; k++)
                begin
                    if (vld_reg[k] && (rem_reg[k] != '0))
                    begin
                        rem_next[k] = rem_reg[k] - DELAY_BITS'(1);
                    end
                end
            end
            stq_pkg::DP_POP:
            begin
                // hold the fired head for a possible re-arm
                pend_id_next  = id_reg[0];
                pend_rel_next = rel_reg[0];
                pend_rst_next = rst_reg[0];
                vld_next      = up_vld;
                rst_next      = up_rst;
                for (int k = 0; k < NUM_TIMERS; k++)
                begin
                    id_next[k]  = up_id[k];
                    rem_next[k] = up_rem[k];
                    rel_next[k] = up_rel[k];
                end
            end
            stq_pkg::DP_REMOVE:
            begin
                for (int k = 0; k < NUM_TIMERS; k++)
                begin
                    if (gone[k])
                    begin
                        vld_next[k] = up_vld[k];
                        rst_next[k] = up_rst[k];
                        id_next[k]  = up_id[k];
                        rem_next[k] = up_rem[k];
                        rel_next[k] = up_rel[k];
                    end
                end
            end
            stq_pkg::DP_INSERT:
            begin
                // new entry goes ahead of the first entry not below its delay
                for (int k = 0; k < NUM_TIMERS; k++)
                begin
                    if (at_pos[k])
                    begin
                        vld_next[k] = 1'b1;
                        rst_next[k] = pend_rst_reg;
                        id_next[k]  = pend_id_reg;
                        rem_next[k] = pend_rel_reg;
                        rel_next[k] = pend_rel_reg;
                    end
                    else if (!lt[k])
                    begin
                        vld_next[k] = dn_vld[k];
                        rst_next[k] = dn_rst[k];
                        id_next[k]  = dn_id[k];
                        rem_next[k] = dn_rem[k];
                        rel_next[k] = dn_rel[k];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= vld_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rst_reg      <= rst_next;
        pend_id_reg  <= pend_id_next;
        pend_rel_reg <= pend_rel_next;
        pend_rst_reg <= pend_rst_next;
        for (int k = 0; k < NUM_TIMERS; k++)
        begin
            id_reg[k]  <= id_next[k];
            rem_reg[k] <= rem_next[k];
            rel_reg[k] <= rel_next[k];
        end
    end

    assign status.head_zero    = vld_reg[0] && (rem_reg[0] == '0);
    assign status.next_zero    = vld_reg[1] && (rem_reg[1] == '0);
    assign status.head_restart = rst_reg[0];
    assign status.head_id      = id_reg[0];
    assign status.queue_busy   = busy_reg;

`ifndef ASSERT_OFF
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot({1'b0, vld_reg} + (NUM_TIMERS + 1)'(1)))
        else $error("timer cells are not a contiguous prefix");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        (op == stq_pkg::DP_INSERT) |-> !vld_reg[NUM_TIMERS-1])
        else $error("insert into a full timer row");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (op == stq_pkg::DP_POP && vld_reg[0])
            |=> ($countones(vld_reg) + 1 == $countones($past(vld_reg))))
        else $error("pop did not remove exactly one timer");
`endif

endmodule

// ===== hw/rtl/stq_controller.sv =====
// ----------------------------------------------------------------------------
// Timer expiry queue controller
// Sequences start, stop and tick commands over the datapath cell row.
// ----------------------------------------------------------------------------
module stq_controller #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  stq_pkg::in_item_t   item,
    input  stq_pkg::dp_status_t status,
    output logic                busy,
    output stq_pkg::dp_op_t     op,
    output stq_pkg::res_ctl_t   res_ctl
);

    localparam int CNT_W = stq_pkg::RES_CNT_W;

    stq_pkg::ctrl_state_t state_reg, state_next;
    logic [CNT_W-1:0]     res_cnt_reg, res_cnt_next;
    logic                 any_fired_reg, any_fired_next;
    logic                 is_start_reg, is_start_next;
    logic                 id_ok;

    assign id_ok = (int'(item.timer_id) < NUM_TIMERS);
    assign busy  = (state_reg != stq_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stq_pkg::ST_IDLE;
            res_cnt_reg   <= '0;
            any_fired_reg <= 1'b0;
            is_start_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_cnt_reg   <= res_cnt_next;
            any_fired_reg <= any_fired_next;
            is_start_reg  <= is_start_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        res_cnt_next   = res_cnt_reg;
        any_fired_next = any_fired_reg;
        is_start_next  = is_start_reg;
        op             = stq_pkg::DP_HOLD;
        res_ctl        = '0;

        unique case (state_reg)
            stq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    unique case (item.command) inside
                        stq_pkg::CMD_TICK:
                        begin
                            state_next = stq_pkg::ST_DEC;
                        end
                        stq_pkg::CMD_START, stq_pkg::CMD_STOP:
                        begin
                            if (id_ok)
                            begin
                                op            = stq_pkg::DP_LOAD;
                                is_start_next = (item.command == stq_pkg::CMD_START);
                                state_next    = stq_pkg::ST_REMOVE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            stq_pkg::ST_DEC:
            begin
                op             = stq_pkg::DP_DEC;
                res_cnt_next   = '0;
                any_fired_next = 1'b0;
                state_next     = stq_pkg::ST_POP;
            end
            stq_pkg::ST_POP:
            begin
                if (status.head_zero)
                begin
                    op             = stq_pkg::DP_POP;
                    any_fired_next = 1'b1;
                    // report only the first MAX_RESULTS expiries
                    if (res_cnt_reg < CNT_W'(stq_pkg::MAX_RESULTS))
                    begin
                        res_ctl.emit = 1'b1;
                        res_ctl.hit  = 1'b1;
                        res_ctl.last = (res_cnt_reg == CNT_W'(stq_pkg::MAX_RESULTS - 1))
                                       || !status.next_zero;
                        res_cnt_next = res_cnt_reg + CNT_W'(1);
                    end
                    state_next = status.head_restart ? stq_pkg::ST_REINS : stq_pkg::ST_POP;
                end
                else
                begin
                    if (!any_fired_reg)
                    begin
                        res_ctl.emit = 1'b1;
                        res_ctl.last = 1'b1;
                    end
                    state_next = stq_pkg::ST_IDLE;
                end
            end
            stq_pkg::ST_REINS:
            begin
                op         = stq_pkg::DP_INSERT;
                state_next = stq_pkg::ST_POP;
            end
            stq_pkg::ST_REMOVE:
            begin
                // removing an idle timer leaves the row unchanged
                op         = stq_pkg::DP_REMOVE;
                state_next = is_start_reg ? stq_pkg::ST_INSERT : stq_pkg::ST_IDLE;
            end
            stq_pkg::ST_INSERT:
            begin
                op         = stq_pkg::DP_INSERT;
                state_next = stq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = stq_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_reins_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == stq_pkg::ST_REINS) |-> ($past(state_reg) == stq_pkg::ST_POP))
        else $error("re-arm without a preceding expiry");

    a_res_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg <= CNT_W'(stq_pkg::MAX_RESULTS))
        else $error("result count beyond limit");

    a_emit_in_pop: assert property (@(posedge clk) disable iff (!rst_n)
        res_ctl.emit |=> (state_reg == stq_pkg::ST_POP || state_reg == stq_pkg::ST_REINS
                          || state_reg == stq_pkg::ST_IDLE))
        else $error("result emitted outside tick handling");
`endif

endmodule
